FILE: hdl/base64_strict_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strict base64 decoder
// Shared concurrent-check forms, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STRICT_DECODER_DEFINES_SVH
`define BASE64_STRICT_DECODER_DEFINES_SVH

// Same-cycle implication check.
`define B64SD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("b64sd same-cycle check failed");

// Next-cycle implication check.
`define B64SD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("b64sd next-cycle check failed");

`endif

FILE: hdl/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, codes and the symbol decode function of the strict base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64sd_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_LEN  = 3'd1,
      ST_BAD_CHAR = 3'd2,
      ST_BAD_PAD  = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_LEFTOVER = 3'd5
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      status_type  status;
      logic [15:0] byte_total;
      logic        end_of_run;
   } beat_type;

   // Which of the two result slots the core pushes this cycle.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sym_type;

   function automatic sym_type symbol_decode(input logic [7:0] c);
      sym_type s;
      s.ok    = 1'b1;
      s.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         s.value = 6'd62;
      end else if (c == 8'h2F) begin
         s.value = 6'd63;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/b64sd_ifs.sv
// ----------------------------------------------------------------------------
// b64sd channel interfaces
// Valid/ready channels for characters, results and the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;
   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b64sd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [2:0]  status;
   logic [15:0] byte_total;
   logic        end_of_run;
   modport source (output valid, output kind, output data_byte, output status,
                   output byte_total, output end_of_run, input ready);
   modport sink   (input valid, input kind, input data_byte, input status,
                   input byte_total, input end_of_run, output ready);
endinterface

interface b64sd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/b64sd_core.sv
// ----------------------------------------------------------------------------
// b64sd_core
// Run state and per-character decode; forms up to two result beats per step.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [7:0]      char_code,
   input  wire logic            last_char,
   input  wire logic [15:0]     capacity,
   output b64sd_pkg::beat_type  beat_a,
   output b64sd_pkg::beat_type  beat_b,
   output b64sd_pkg::push_type  push
);
   import b64sd_pkg::*;

   logic [11:0] window_ff, window_in;
   logic [2:0]  held_ff, held_in;
   logic [1:0]  count_ff, count_in;
   logic        pad_ff, pad_in;
   status_type  err_ff, err_in;
   logic [15:0] bytes_ff, bytes_in;

   sym_type     sym;
   logic [3:0]  held_sum;
   logic        emit;
   logic [7:0]  byte_val;
   status_type  final_st;
   beat_type    data_beat;
   beat_type    stat_beat;

   always_comb begin
      window_in = window_ff;
      held_in   = held_ff;
      pad_in    = pad_ff;
      err_in    = err_ff;
      bytes_in  = bytes_ff;
      count_in  = count_ff + 2'd1;
      emit      = 1'b0;
      sym       = symbol_decode(char_code);
      held_sum  = {1'b0, held_ff} + 4'd6;
      if (err_ff == ST_OK) begin
         if (char_code == PAD_CHAR) begin
            pad_in = 1'b1;
         end else if (pad_ff) begin
            err_in = ST_BAD_PAD;
         end else if (!sym.ok) begin
            err_in = ST_BAD_CHAR;
         end else begin
            window_in = {window_ff[5:0], sym.value};
            if (held_sum >= 4'd8) begin
               held_in = 3'(held_sum - 4'd8);
               if (bytes_ff >= capacity) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  bytes_in = bytes_ff + 16'd1;
                  emit     = 1'b1;
               end
            end else begin
               held_in = held_sum[2:0];
            end
         end
      end

      // A byte always ends on a held count of zero, two or four.
      case (held_in)
         3'd2:    byte_val = window_in[9:2];
         3'd4:    byte_val = window_in[11:4];
         default: byte_val = window_in[7:0];
      endcase

      if (count_in != 2'd0) begin
         final_st = ST_BAD_LEN;
      end else if (err_in == ST_OK && held_in >= 3'd6) begin
         final_st = ST_LEFTOVER;
      end else begin
         final_st = err_in;
      end

      data_beat.kind       = KIND_DATA;
      data_beat.data_byte  = byte_val;
      data_beat.status     = ST_OK;
      data_beat.byte_total = bytes_in;
      data_beat.end_of_run = !last_char;

      stat_beat.kind       = KIND_STATUS;
      stat_beat.data_byte  = 8'd0;
      stat_beat.status     = final_st;
      stat_beat.byte_total = bytes_in;
      stat_beat.end_of_run = 1'b1;

      if (emit) begin
         beat_a      = data_beat;
         beat_b      = stat_beat;
         push.first  = step;
         push.second = step && last_char;
      end else begin
         beat_a      = stat_beat;
         beat_b      = stat_beat;
         push.first  = step && last_char;
         push.second = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_char)) begin
         window_ff <= '0;
         held_ff   <= '0;
         count_ff  <= '0;
         pad_ff    <= 1'b0;
         err_ff    <= ST_OK;
         bytes_ff  <= '0;
      end else if (step) begin
         window_ff <= window_in;
         held_ff   <= held_in;
         count_ff  <= count_in;
         pad_ff    <= pad_in;
         err_ff    <= err_in;
         bytes_ff  <= bytes_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/b64sd_rsp_fifo.sv
// ----------------------------------------------------------------------------
// b64sd_rsp_fifo
// Small result queue: takes up to two beats a cycle, hands out one while rsp is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sd_rsp_fifo (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire b64sd_pkg::beat_type         beat_a,
   input  wire b64sd_pkg::beat_type         beat_b,
   input  wire b64sd_pkg::push_type         push,
   output logic [b64sd_pkg::RSP_CNT_W-1:0]  fill,
   b64sd_rsp_if.source                      rsp
);
   import b64sd_pkg::*;

   beat_type               mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ff, wr_in;
   logic [RSP_PTR_W-1:0]   rd_ff, rd_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;
   beat_type               head;

   assign pop  = rsp.valid && rsp.ready;
   assign head = mem[rd_ff];
   assign fill = count_ff;

   assign rsp.valid      = (count_ff != '0);
   assign rsp.kind       = head.kind;
   assign rsp.data_byte  = head.data_byte;
   assign rsp.status     = head.status;
   assign rsp.byte_total = head.byte_total;
   assign rsp.end_of_run = head.end_of_run;

   always_comb begin
      wr_in    = wr_ff + RSP_PTR_W'(push.first) + RSP_PTR_W'(push.second);
      rd_in    = rd_ff + RSP_PTR_W'(pop);
      count_in = count_ff + RSP_CNT_W'(push.first) + RSP_CNT_W'(push.second)
                 - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem[wr_ff] <= beat_a;
      end
      if (push.second) begin
         mem[RSP_PTR_W'(wr_ff + RSP_PTR_W'(1))] <= beat_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/base64_strict_decoder.sv
// ----------------------------------------------------------------------------
// base64_strict_decoder: base64 characters in, data and status beats out
// Path: input register, core, result queue; last char yields up to two beats.
// Throughput: one character per cycle while the queue has room for two beats.
// Reset: synchronous, clears run state, queue and capacity (to 65535).
// ----------------------------------------------------------------------------
`default_nettype none
`include "base64_strict_decoder_defines.svh"

module base64_strict_decoder (
   input  wire logic     clock,
   input  wire logic     reset,
   b64sd_req_if.sink     req_ch,
   b64sd_rsp_if.source   rsp_ch,
   b64sd_csr_if.sink     csr_ch
);
   import b64sd_pkg::*;

   // Input register: one character beat waiting for the core.
   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff;
   logic                   in_last_ff;

   // Output capacity: user must write it only between strings; not enforced.
   logic [15:0]            capacity_ff;

   logic                   process;
   logic                   req_take;
   logic [RSP_CNT_W-1:0]   rsp_fill;
   beat_type               beat_a;
   beat_type               beat_b;
   push_type               push;

   // Process the held character only when the queue has room for two beats,
   // the worst case of a data byte followed by the status beat.
   assign process = in_valid_ff && (rsp_fill <= RSP_CNT_W'(RSP_DEPTH - 2));

   // Take a new character whenever the input register is empty or drains now.
   assign req_ch.ready = !in_valid_ff || process;
   assign req_take     = req_ch.valid && req_ch.ready;

   // The capacity register is always writable.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (process) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         capacity_ff <= 16'hFFFF;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            capacity_ff <= csr_ch.data;
         end
      end
   end

   // Payload of the input register: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_ch.char_code;
         in_last_ff <= req_ch.last_char;
      end
   end

   // Decode the character, advance the run state, form the result beats.
   b64sd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (process),
      .char_code (in_char_ff),
      .last_char (in_last_ff),
      .capacity  (capacity_ff),
      .beat_a    (beat_a),
      .beat_b    (beat_b),
      .push      (push)
   );

   // Queue the beats and drive them out one per cycle while rsp_ch is ready.
   b64sd_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .beat_a (beat_a),
      .beat_b (beat_b),
      .push   (push),
      .fill   (rsp_fill),
      .rsp    (rsp_ch)
   );

   // A status beat always closes its character's results.
   `B64SD_ASSERT_IMP(a_status_ends_run, clock, reset,
      rsp_ch.valid && rsp_ch.kind == KIND_STATUS, rsp_ch.end_of_run)

   // The queue never overfills.
   `B64SD_ASSERT_IMP(a_fill_bound, clock, reset,
      1'b1, rsp_fill <= RSP_CNT_W'(RSP_DEPTH))

   // A held character that is not processed keeps its value.
   `B64SD_ASSERT_NXT(a_hold_input, clock, reset,
      in_valid_ff && !process, in_valid_ff && $stable(in_char_ff))

endmodule

`default_nettype wire

FILE: sim/tb_base64_strict_decoder.sv
// ----------------------------------------------------------------------------
// tb_base64_strict_decoder
// Self-checking bench for the strict base64 decoder. Strings are sent one
// character per beat, each accepted character is run through a behavioral
// decoder in the bench, and every result beat is checked field by field
// against the oldest predicted beat. Both sides idle at random, the result
// side holds off once for a long stretch, and the capacity register is
// changed between phases.
// ----------------------------------------------------------------------------
module tb_base64_strict_decoder;
   import b64sd_pkg::*;

   // Cycles to let pass after the last predicted beat before touching the
   // capacity register or ending: a character that yields no beat may still
   // be in the pipe.
   localparam int DRAIN_PAD   = 8;
   // Long result hold-off: start it once this many characters went in.
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 120;
   // The slowest correct run is roughly 1300 characters, each with random source
   // idle gaps, up to two result beats with random stalls and the path through
   // the block, plus the hold-off and the phase drains. Allow close to ten times that.
   localparam int TIMEOUT     = 3_000_000;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_item_type;

   logic clock;
   logic reset;

   b64sd_req_if req_ch ();
   b64sd_rsp_if rsp_ch ();
   b64sd_csr_if csr_ch ();

   base64_strict_decoder uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Characters waiting to go out, and result beats waiting to come back.
   char_item_type pending_chars[$];
   beat_type expected_beats[$];

   int  errors     = 0;
   int  char_beats = 0;
   int  src_gap    = 0;
   int  sink_gap   = 0;
   logic calm      = 1'b0;   // no idling on either side when set
   logic hold_rsp  = 1'b0;   // long result hold-off in progress
   char_item_type next_char;
   beat_type want_beat;

   // Behavioral decoder state, at the block's widths.
   logic [11:0] win        = '0;
   logic [2:0]  held       = '0;
   logic [1:0]  quad_pos   = '0;
   logic        pad_seen   = 1'b0;
   status_type  run_err    = ST_OK;
   logic [15:0] byte_count = '0;
   logic [15:0] out_capacity = 16'hFFFF;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ----------------------------------------------------------------------
   // Alphabet helpers
   // ----------------------------------------------------------------------
   function automatic logic base64_value(input logic [7:0] c, output logic [5:0] v);
      v = 6'd0;
      if (c >= "A" && c <= "Z") v = 6'(c - "A");
      else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
      else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
      else if (c == "+") v = 6'd62;
      else if (c == "/") v = 6'd63;
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] base64_char(input logic [5:0] v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      if (v == 62) return "+";
      return "/";
   endfunction

   // ----------------------------------------------------------------------
   // Predict the result beats of one accepted character
   // ----------------------------------------------------------------------
   function automatic void decode_char(input logic [7:0] code, input logic last);
      beat_type b;
      logic [5:0] sym;
      int fill;
      quad_pos = quad_pos + 2'd1;
      // First error wins: after it only the length count moves.
      if (run_err == ST_OK) begin
         if (code == PAD_CHAR) begin
            pad_seen = 1'b1;
         end else if (pad_seen) begin
            run_err = ST_BAD_PAD;
         end else if (!base64_value(code, sym)) begin
            run_err = ST_BAD_CHAR;
         end else begin
            win  = {win[5:0], sym};
            fill = held + 6;
            if (fill >= 8) begin
               held = 3'(fill - 8);
               // A byte past the capacity is dropped and flags overflow.
               if (byte_count >= out_capacity) begin
                  run_err = ST_OVERFLOW;
               end else begin
                  byte_count   = byte_count + 16'd1;
                  b.kind       = KIND_DATA;
                  b.data_byte  = 8'(win >> held);
                  b.status     = ST_OK;
                  b.byte_total = byte_count;
                  b.end_of_run = !last;
                  expected_beats.push_back(b);
               end
            end else begin
               held = 3'(fill);
            end
         end
      end
      if (last) begin
         // Bad length outranks everything; leftover bits only if clean.
         b.kind       = KIND_STATUS;
         b.data_byte  = 8'd0;
         b.status     = run_err;
         if (quad_pos != 2'd0) b.status = ST_BAD_LEN;
         else if (run_err == ST_OK && held >= 3'd6) b.status = ST_LEFTOVER;
         b.byte_total = byte_count;
         b.end_of_run = 1'b1;
         expected_beats.push_back(b);
         win        = '0;
         held       = '0;
         quad_pos   = '0;
         pad_seen   = 1'b0;
         run_err    = ST_OK;
         byte_count = '0;
      end
   endfunction

   // ----------------------------------------------------------------------
   // Stimulus builders: each one appends a whole string to pending_chars
   // ----------------------------------------------------------------------
   task automatic queue_bytes(input logic [7:0] text[$]);
      char_item_type it;
      foreach (text[i]) begin
         it.code = text[i];
         it.last = (i == text.size() - 1);
         pending_chars.push_back(it);
      end
   endtask

   task automatic queue_string(input string s);
      logic [7:0] text[$];
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      queue_bytes(text);
   endtask

   // Encode nbytes random bytes, then optionally damage the text.
   // flaw: 0 none, 1 overwrite a char, 2 drop a char, 3 insert a symbol,
   // 4 stray pad inside, 5 random tail symbol (stray low bits), 6 strip pads.
   task automatic queue_encoded(input int nbytes, input int flaw);
      logic [7:0]  text[$];
      logic [23:0] group;
      int rem, pos;
      for (int k = 0; k < nbytes; k += 3) begin
         rem   = nbytes - k;
         group = {8'($urandom), rem > 1 ? 8'($urandom) : 8'h00,
                  rem > 2 ? 8'($urandom) : 8'h00};
         text.push_back(base64_char(group[23:18]));
         text.push_back(base64_char(group[17:12]));
         text.push_back(rem > 1 ? base64_char(group[11:6]) : PAD_CHAR);
         text.push_back(rem > 2 ? base64_char(group[5:0]) : PAD_CHAR);
      end
      pos = $urandom_range(0, text.size() - 1);
      case (flaw)
         1: begin
            text[pos] = 8'($urandom);
         end
         2: begin
            text.delete(pos);
         end
         3: begin
            text.insert(pos, base64_char(6'($urandom)));
         end
         4: begin
            text[$urandom_range(0, text.size() - 2)] = PAD_CHAR;
         end
         5: begin
            pos = text.size() - 1;
            while (pos > 0 && text[pos] == PAD_CHAR) pos--;
            text[pos] = base64_char(6'($urandom));
         end
         6: begin
            while (text.size() > 1 && text[text.size() - 1] == PAD_CHAR) begin
               void'(text.pop_back());
            end
         end
         default: begin
         end
      endcase
      queue_bytes(text);
   endtask

   // Short strings of mixed symbols and raw bytes.
   task automatic queue_noise();
      logic [7:0] text[$];
      int len;
      len = $urandom_range(1, 12);
      repeat (len) begin
         if ($urandom_range(0, 2) == 0) text.push_back(8'($urandom));
         else if ($urandom_range(0, 5) == 0) text.push_back(PAD_CHAR);
         else text.push_back(base64_char(6'($urandom)));
      end
      queue_bytes(text);
   endtask

   // Odd tails: pad-only strings, or one symbol too many (6 leftover bits).
   task automatic queue_odd_tail();
      logic [7:0] text[$];
      int groups;
      groups = $urandom_range(0, 2);
      if ($urandom_range(0, 1) == 0) begin
         repeat (4 * groups + 4) text.push_back(PAD_CHAR);
      end else begin
         repeat (4 * groups + 1) text.push_back(base64_char(6'($urandom)));
         repeat (3) text.push_back(PAD_CHAR);
      end
      queue_bytes(text);
   endtask

   // Mostly well-formed strings with random content, the rest broken.
   task automatic queue_random(input int nitems);
      int start, mode, nbytes;
      start = pending_chars.size();
      while (pending_chars.size() - start < nitems) begin
         mode   = $urandom_range(0, 19);
         nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 48)
                                               : $urandom_range(1, 9);
         if (mode < 12) queue_encoded(nbytes, 0);
         else if (mode < 16) queue_encoded(nbytes, $urandom_range(1, 6));
         else if (mode < 18) queue_noise();
         else queue_odd_tail();
      end
   endtask

   // Wait until every character is in and every predicted beat is out,
   // then give a character with no beat time to clear the pipe.
   task automatic settle();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_ch.valid || expected_beats.size() != 0);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      out_capacity = value;
   endtask

   // ----------------------------------------------------------------------
   // Character driver: hold a beat until taken, idle in random bursts
   // ----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         src_gap = 0;
      end else begin
         // Predict on the beat the block takes at this edge.
         if (req_ch.valid && req_ch.ready) begin
            decode_char(req_ch.char_code, req_ch.last_char);
            char_beats++;
         end
         // Advance only when the wire is free; one assignment per signal.
         if (!req_ch.valid || req_ch.ready) begin
            if (src_gap == 0 && pending_chars.size() != 0) begin
               next_char = pending_chars.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.char_code <= next_char.code;
               req_ch.last_char <= next_char.last;
               if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 6);
            end else begin
               if (src_gap != 0) src_gap--;
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ----------------------------------------------------------------------
   // Result monitor: stall in random bursts, check each beat taken
   // ----------------------------------------------------------------------
   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t ERROR %s: expected %0d actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t ERROR stray beat: expected none actual kind %0d data %0d",
                        $time, rsp_ch.kind, rsp_ch.data_byte);
               $display("   status %0d total %0d end %0d",
                        rsp_ch.status, rsp_ch.byte_total, rsp_ch.end_of_run);
               errors++;
            end else begin
               want_beat = expected_beats.pop_front();
               check_field("kind", want_beat.kind, rsp_ch.kind);
               check_field("data_byte", want_beat.data_byte, rsp_ch.data_byte);
               check_field("status", want_beat.status, rsp_ch.status);
               check_field("byte_total", want_beat.byte_total, rsp_ch.byte_total);
               check_field("end_of_run", want_beat.end_of_run, rsp_ch.end_of_run);
            end
         end
         if (sink_gap != 0) sink_gap--;
         else if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 6);
         rsp_ch.ready <= !hold_rsp && sink_gap == 0;
      end
   end

   // ----------------------------------------------------------------------
   // Long hold-off on the result side while characters keep coming, so the
   // result queue fills and the block stalls its input.
   // ----------------------------------------------------------------------
   initial begin
      do @(negedge clock); while (char_beats < HOLD_AT);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rsp <= 1'b0;
   end

   // ----------------------------------------------------------------------
   // Run limit
   // ----------------------------------------------------------------------
   initial begin
      #TIMEOUT;
      $display("DONE: errors detected");
      $finish;
   end

   // ----------------------------------------------------------------------
   // Phases
   // ----------------------------------------------------------------------
   initial begin
      // Known values on every input from time zero.
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.char_code = 8'd0;
      req_ch.last_char = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.data      = 16'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed strings at the reset capacity: all-zero and all-one
      // symbols, plus, digit and lowercase symbols with stray low bits, six
      // leftover bits, pads only, a symbol after a pad, a top-bit byte, and a
      // short string that also holds a bad char (length wins).
      @(negedge clock);
      queue_string("AA//");
      queue_string("+9a=");
      queue_string("A===");
      queue_string("====");
      queue_string("A=BC");
      queue_string("Ab\377D");
      queue_string("Q*=");
      settle();

      // Zero capacity: the first byte overflows; no-byte strings keep their status.
      write_capacity(16'd0);
      @(negedge clock);
      queue_string("AAAA");
      queue_string("====");
      queue_string("A===");
      settle();

      // Small capacity: overflow is common. The hold-off lands here.
      write_capacity(16'd3);
      @(negedge clock);
      queue_random(300);
      settle();

      write_capacity(16'hFFFF);
      @(negedge clock);
      queue_random(400);
      settle();

      write_capacity(16'($urandom));
      @(negedge clock);
      queue_random(250);
      settle();

      // Last stretch with no idling on either side.
      write_capacity(16'd5);
      @(negedge clock);
      calm = 1'b1;
      queue_random(250);
      settle();

      if (errors == 0 && expected_beats.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/b64sd_pkg.sv
hdl/b64sd_ifs.sv
hdl/b64sd_core.sv
hdl/b64sd_rsp_fifo.sv
hdl/base64_strict_decoder.sv
sim/tb_base64_strict_decoder.sv
